// File: src/kss_pkg.sv
`timescale 1ns / 1ps

package kss_pkg;

    // sizing
    localparam int PATTERN_MAX   = 64;
    localparam int POSITION_BITS = 32;
    localparam int ADDR_W        = $clog2(PATTERN_MAX);
    localparam int CNT_W         = $clog2(PATTERN_MAX + 1);
    localparam int DATA_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int POS_OUT_W     = 32;
    localparam int CMP_W         = (POSITION_BITS + 1 > CNT_W) ? POSITION_BITS + 1 : CNT_W;

    // saturation value of the text index
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // item kinds
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SEARCHING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_AFTER     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOMATCH   = 3'd5;

    // failure entry: neg set means -1
    typedef struct packed {
        logic              neg;
        logic [ADDR_W-1:0] idx;
    } t_fidx;

    localparam int FAIL_W = $bits(t_fidx);

    // controller to datapath
    typedef struct packed {
        logic start;
        logic walk;
        logic fin;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_walk;
        logic walk_done;
        logic is_build;
        logic slot_free;
    } t_sts;

endpackage

// File: src/kss_if.sv
`timescale 1ns / 1ps

// input request channel
interface kss_in_if;
    import kss_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [DATA_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

// result request channel
interface kss_out_if;
    import kss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [POS_OUT_W-1:0] position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

// File: src/kmp_string_search_core.sv
`timescale 1ns / 1ps

// First-occurrence KMP search over a byte stream, with a 64-entry pattern
// memory and a nextval failure memory built as pattern bytes arrive. Every
// accepted byte gives exactly one result. The failure chain is walked one
// step per cycle through the registered read ports of the two memories. A
// new byte is taken only after the result of the last one is registered.
// Bytes that need no walk are the first pattern byte, overflow, empty
// pattern and text after a match; other text and pattern bytes walk the
// chain, and a later pattern byte then also writes its nextval entry. A
// result waiting on the output holds the block until the slot frees. No
// clearing pass runs after reset.
module kmp_string_search_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kss_in_if.sink     i_in,
    kss_out_if.source  o_out
);
    import kss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    kss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // search datapath and memories
    kss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_in.kind),
        .i_data_byte (i_in.data_byte),
        .i_last      (i_in.last),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_position  (o_out.position)
    );

endmodule

// File: src/kss_ram.sv
`timescale 1ns / 1ps

module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kss_ctrl.sv
`timescale 1ns / 1ps

module kss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kss_pkg::t_sts i_sts,
    output kss_pkg::t_cmd o_cmd
);
    import kss_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // commands
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cmd.start = (r_state == S_IDLE) && i_in_valid;
        o_cmd.walk  = (r_state == S_WALK);
        o_cmd.fin   = (r_state == S_FIN);
        o_cmd.emit  = (r_state == S_EMIT) && i_sts.slot_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.need_walk ? S_WALK : S_EMIT;
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = i_sts.is_build ? S_FIN : S_EMIT;
                end
            end
            S_FIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/kss_dp.sv
`timescale 1ns / 1ps

module kss_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kss_pkg::t_cmd                   i_cmd,
    output kss_pkg::t_sts                   o_sts,
    input  logic                            i_kind,
    input  logic [kss_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                            i_last,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [kss_pkg::STATUS_W-1:0]    o_status,
    output logic [kss_pkg::POS_OUT_W-1:0]   o_position
);
    import kss_pkg::*;

    // control state
    logic [CNT_W-1:0]         r_count,     n_count;
    t_fidx                    r_bidx,      n_bidx;
    logic [ADDR_W-1:0]        r_match,     n_match;
    logic [POSITION_BITS-1:0] r_text,      n_text;
    logic                     r_found,     n_found;
    logic                     r_ovf,       n_ovf;
    logic                     r_closed,    n_closed;
    logic                     r_build,     n_build;
    logic                     r_out_valid, n_out_valid;

    // working payload
    t_fidx                    r_j,         n_j;
    logic [DATA_W-1:0]        r_key,       n_key;
    logic [DATA_W-1:0]        r_byte,      n_byte;
    logic [DATA_W-1:0]        r_prev,      n_prev;
    logic                     r_last,      n_last;
    logic [ADDR_W-1:0]        r_i,         n_i;
    logic [POSITION_BITS-1:0] r_idx,       n_idx;
    logic [STATUS_W-1:0]      r_res_st,    n_res_st;
    logic [POS_OUT_W-1:0]     r_res_pos,   n_res_pos;
    logic [STATUS_W-1:0]      r_out_st,    n_out_st;
    logic [POS_OUT_W-1:0]     r_out_pos,   n_out_pos;

    // memory ports
    logic                     p_we;
    logic [DATA_W-1:0]        p_rdata;
    logic                     f_we;
    t_fidx                    f_wdata;
    logic [FAIL_W-1:0]        f_rdata_raw;
    t_fidx                    f_rdata;
    logic [ADDR_W-1:0]        wr_addr;

    // helpers
    logic [CNT_W-1:0]         eff_count;
    t_fidx                    eff_bidx;
    logic                     eff_ovf;
    logic                     walk_exit;
    logic [CNT_W-1:0]         m_next;
    logic [CMP_W-1:0]         pos_end;
    logic [CMP_W-1:0]         pos_cnt;
    logic [CMP_W-1:0]         pos_diff;
    logic [POS_OUT_W-1:0]     match_pos;
    logic                     need_walk;

    kss_ram #(.WIDTH(DATA_W), .DEPTH(PATTERN_MAX)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (wr_addr),
        .i_wdata (i_data_byte),
        .i_raddr (n_j.idx),
        .o_rdata (p_rdata)
    );

    kss_ram #(.WIDTH(FAIL_W), .DEPTH(PATTERN_MAX)) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (wr_addr),
        .i_wdata (f_wdata),
        .i_raddr (n_j.idx),
        .o_rdata (f_rdata_raw)
    );

    assign f_rdata = t_fidx'(f_rdata_raw);

    // pattern state seen by a new pattern byte after a closed pattern
    assign eff_count = r_closed ? '0 : r_count;
    assign eff_ovf   = r_closed ? 1'b0 : r_ovf;
    always_comb begin
        eff_bidx = r_bidx;
        if (r_closed) begin
            eff_bidx.neg = 1'b1;
            eff_bidx.idx = '0;
        end
    end

    // one failure-chain step per cycle
    assign walk_exit = r_j.neg || (p_rdata == r_key);
    assign m_next    = r_j.neg ? '0 : CNT_W'(r_j.idx) + CNT_W'(1);

    // match start position from the saturated text index
    assign pos_end   = CMP_W'(r_idx) + CMP_W'(1);
    assign pos_cnt   = CMP_W'(r_count);
    assign pos_diff  = pos_end - pos_cnt;
    assign match_pos = (pos_end >= pos_cnt) ? POS_OUT_W'(pos_diff) : '0;

    always_comb begin
        n_count     = r_count;
        n_bidx      = r_bidx;
        n_match     = r_match;
        n_text      = r_text;
        n_found     = r_found;
        n_ovf       = r_ovf;
        n_closed    = r_closed;
        n_build     = r_build;
        n_out_valid = r_out_valid;
        n_j         = r_j;
        n_key       = r_key;
        n_byte      = r_byte;
        n_prev      = r_prev;
        n_last      = r_last;
        n_i         = r_i;
        n_idx       = r_idx;
        n_res_st    = r_res_st;
        n_res_pos   = r_res_pos;
        n_out_st    = r_out_st;
        n_out_pos   = r_out_pos;
        p_we        = 1'b0;
        f_we        = 1'b0;
        f_wdata     = r_j;
        wr_addr     = r_i;
        need_walk   = 1'b0;

        if (i_cmd.start) begin
            n_last    = i_last;
            n_res_pos = '0;
            if (i_kind == KIND_PATTERN) begin
                // pattern byte: clear search, maybe start a new pattern
                n_closed = i_last;
                n_match  = '0;
                n_text   = '0;
                n_found  = 1'b0;
                n_count  = eff_count;
                n_bidx   = eff_bidx;
                n_ovf    = eff_ovf;
                n_build  = 1'b1;
                if (eff_ovf || (eff_count >= CNT_W'(PATTERN_MAX))) begin
                    n_ovf    = 1'b1;
                    n_res_st = ST_OVERFLOW;
                end else begin
                    wr_addr = eff_count[ADDR_W-1:0];
                    p_we    = 1'b1;
                    n_i     = eff_count[ADDR_W-1:0];
                    n_byte  = i_data_byte;
                    if (eff_count == '0) begin
                        // first byte: entry is -1
                        f_we         = 1'b1;
                        f_wdata.neg  = 1'b1;
                        f_wdata.idx  = '0;
                        n_bidx.neg   = 1'b1;
                        n_bidx.idx   = '0;
                        n_count      = CNT_W'(1);
                        n_prev       = i_data_byte;
                        n_res_st     = ST_LOADED;
                    end else begin
                        need_walk = 1'b1;
                        n_j       = eff_bidx;
                        n_key     = r_prev;
                    end
                end
            end else begin
                // text byte
                n_build = 1'b0;
                n_idx   = r_text;
                if (i_last) begin
                    n_text = '0;
                end else if (r_text != POS_MAX) begin
                    n_text = r_text + POSITION_BITS'(1);
                end
                if (r_ovf) begin
                    n_res_st = ST_OVERFLOW;
                end else if (r_found) begin
                    n_res_st = ST_AFTER;
                end else if (r_count == '0) begin
                    n_found  = 1'b1;
                    n_res_st = ST_MATCH;
                end else begin
                    need_walk = 1'b1;
                    n_j.neg   = 1'b0;
                    n_j.idx   = r_match;
                    n_key     = i_data_byte;
                end
                if (i_last && !need_walk) begin
                    n_match = '0;
                    n_found = 1'b0;
                end
            end
        end else if (i_cmd.walk) begin
            if (!walk_exit) begin
                n_j = f_rdata;
            end else if (r_build) begin
                n_j.neg = 1'b0;
                n_j.idx = m_next[ADDR_W-1:0];
            end else begin
                n_match = m_next[ADDR_W-1:0];
                if (m_next == r_count) begin
                    n_found   = 1'b1;
                    n_res_st  = ST_MATCH;
                    n_res_pos = match_pos;
                end else begin
                    n_res_st = r_last ? ST_NOMATCH : ST_SEARCHING;
                end
                if (r_last) begin
                    n_match = '0;
                    n_found = 1'b0;
                end
            end
        end else if (i_cmd.fin) begin
            // nextval entry for the new byte
            f_we     = 1'b1;
            f_wdata  = (p_rdata == r_byte) ? f_rdata : r_j;
            n_bidx   = r_j;
            n_count  = CNT_W'(r_i) + CNT_W'(1);
            n_prev   = r_byte;
            n_res_st = ST_LOADED;
        end

        // output register
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_st    = r_res_st;
            n_out_pos   = r_res_pos;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_sts.need_walk = need_walk;
        o_sts.walk_done = i_cmd.walk && walk_exit;
        o_sts.is_build  = r_build;
        o_sts.slot_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_position  = r_out_pos;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bidx.neg  <= 1'b1;
            r_bidx.idx  <= '0;
            r_match     <= '0;
            r_text      <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_closed    <= 1'b0;
            r_build     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_bidx      <= n_bidx;
            r_match     <= n_match;
            r_text      <= n_text;
            r_found     <= n_found;
            r_ovf       <= n_ovf;
            r_closed    <= n_closed;
            r_build     <= n_build;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_key     <= n_key;
        r_byte    <= n_byte;
        r_prev    <= n_prev;
        r_last    <= n_last;
        r_i       <= n_i;
        r_idx     <= n_idx;
        r_res_st  <= n_res_st;
        r_res_pos <= n_res_pos;
        r_out_st  <= n_out_st;
        r_out_pos <= n_out_pos;
    end

endmodule

// File: src/kss_checker.sv
`timescale 1ns / 1ps

module kss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [kss_pkg::STATUS_W-1:0]    i_status,
    input logic [kss_pkg::POS_OUT_W-1:0]   i_position
);
    import kss_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;
    logic [1:0] n_pending;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // requests accepted and not yet answered
    always_comb begin
        n_pending = r_pending;
        if (in_acc && !out_acc && (r_pending != 2'd3)) begin
            n_pending = r_pending + 2'd1;
        end else if (!in_acc && out_acc && (r_pending != 2'd0)) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 2'd0))
        else $error("result without pending request");

    // at most one request in flight besides the held result
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many pending requests");

    // position is zero unless a match is reported
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_MATCH)) |-> (i_position == '0))
        else $error("nonzero position without match");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_position)))
        else $error("stalled result changed");

endmodule

bind kmp_string_search_core kss_checker u_kss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_position  (o_out.position)
);

// File: test/tb_kmp_string_search_core.sv
`timescale 1ns / 1ps

module tb_kmp_string_search_core;
    import kss_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int BYTE_TARGET   = 1950;
    localparam int MAX_WAIT      = 17;
    localparam int SETTLE_CYCLES = 40;

    // one expected search answer
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_OUT_W-1:0] position;
    } t_search_answer;

    // kmp predictor plus queue of answers still owed by the block
    class search_scoreboard;
        logic [DATA_W-1:0] pat_mem [PATTERN_MAX];
        int                next_mem [PATTERN_MAX];
        int                pat_len;
        int                prefix_idx;
        int                match_len;
        longint unsigned   text_pos;
        bit                found;
        bit                overflowed;
        bit                closed;
        t_search_answer    answer_q [$];
        int                n_errors;

        function new();
            foreach (pat_mem[i]) begin
                pat_mem[i]  = '0;
                next_mem[i] = 0;
            end
            pat_len    = 0;
            prefix_idx = -1;
            overflowed = 0;
            closed     = 0;
            n_errors   = 0;
            restart_text();
        endfunction

        function void restart_text();
            match_len = 0;
            text_pos  = 0;
            found     = 0;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        // load one pattern byte and extend the nextval table
        function logic [STATUS_W-1:0] load_pattern(logic [DATA_W-1:0] b, bit is_last);
            int i;
            int j;
            if (closed) begin
                pat_len    = 0;
                prefix_idx = -1;
                overflowed = 0;
                closed     = 0;
            end
            restart_text();
            if (is_last)
                closed = 1;
            if (overflowed || pat_len >= PATTERN_MAX) begin
                overflowed = 1;
                return ST_OVERFLOW;
            end
            i = pat_len;
            pat_mem[i] = b;
            if (i == 0) begin
                next_mem[0] = -1;
                prefix_idx  = -1;
            end else begin
                j = prefix_idx;
                while (j != -1 && pat_mem[j] != pat_mem[i-1])
                    j = next_mem[j];
                j++;
                if (pat_mem[j] == b)
                    next_mem[i] = next_mem[j];
                else
                    next_mem[i] = j;
                prefix_idx = j;
            end
            pat_len = i + 1;
            return ST_LOADED;
        endfunction

        // scan one text byte against the stored pattern
        function t_search_answer scan_text(logic [DATA_W-1:0] c, bit is_last);
            t_search_answer  r;
            longint unsigned idx;
            longint unsigned plen;
            longint unsigned pos_top;
            r.status   = ST_SEARCHING;
            r.position = '0;
            idx     = text_pos;
            plen    = longint'(pat_len);
            pos_top = 64'(POS_MAX);
            if (text_pos < pos_top)
                text_pos++;
            if (overflowed) begin
                r.status = ST_OVERFLOW;
            end else if (found) begin
                r.status = ST_AFTER;
            end else if (pat_len == 0) begin
                found    = 1;
                r.status = ST_MATCH;
            end else begin
                while (match_len != -1 && pat_mem[match_len] != c)
                    match_len = next_mem[match_len];
                match_len++;
                if (match_len == pat_len) begin
                    found      = 1;
                    r.position = (idx + 1 >= plen) ? POS_OUT_W'(idx + 1 - plen) : '0;
                    r.status   = ST_MATCH;
                end else begin
                    r.status = is_last ? ST_NOMATCH : ST_SEARCHING;
                end
            end
            if (is_last)
                restart_text();
            return r;
        endfunction

        // accepted input byte: predict its answer
        function void note_byte(logic kind, logic [DATA_W-1:0] b, logic is_last);
            t_search_answer r;
            if (kind == KIND_TEXT) begin
                r = scan_text(b, is_last);
            end else begin
                r.status   = load_pattern(b, is_last);
                r.position = '0;
            end
            answer_q.push_back(r);
        endfunction

        // accepted result: compare with the oldest prediction
        function void check_answer(logic [STATUS_W-1:0] st, logic [POS_OUT_W-1:0] pos);
            t_search_answer exp_r;
            if (answer_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d position %0d",
                         $time, st, pos);
                n_errors++;
                return;
            end
            exp_r = answer_q.pop_front();
            if (st !== exp_r.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_r.status, st);
                n_errors++;
            end
            if (pos !== exp_r.position) begin
                $display("%0t: position mismatch: expected %0d actual %0d",
                         $time, exp_r.position, pos);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kss_in_if  in_if ();
    kss_out_if out_if ();

    search_scoreboard sb;
    int               bytes_sent;
    int               cycle_count;
    bit               in_calm;
    bit               out_calm;

    kmp_string_search_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[kmp_string_search_core] ERROR");
            $finish;
        end
    end

    // drive one byte request and wait for its acceptance
    task automatic send_byte(input logic kind, input logic [DATA_W-1:0] b, input logic is_last);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.data_byte <= b;
        in_if.last      <= is_last;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.note_byte(kind, b, is_last);
        bytes_sent++;
    endtask

    // hold off the sender until every answer is back
    task automatic drain_answers();
        in_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // one pattern, one to three texts drawn like the pattern, maybe some noise
    task automatic run_round(input int plen_req);
        logic [DATA_W-1:0] sym [3];
        logic [DATA_W-1:0] pat [$];
        logic [DATA_W-1:0] txt [$];
        int                nsym;
        int                plen;
        int                tlen;
        int                ntexts;
        int                at;
        int                pick;
        bit                wide;
        bit                close_pat;
        bit                close_txt;
        for (int s = 0; s < 3; s++)
            sym[s] = DATA_W'($urandom_range(0, 255));
        nsym = $urandom_range(1, 3);
        wide = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        if (plen_req > 0)
            plen = plen_req;
        else if (pick < 3)
            plen = $urandom_range(PATTERN_MAX, PATTERN_MAX + 6);
        else if (pick < 13)
            plen = $urandom_range(9, 20);
        else
            plen = $urandom_range(1, 8);

        // pattern load
        for (int i = 0; i < plen; i++)
            pat.push_back(wide ? DATA_W'($urandom_range(0, 255))
                               : sym[$urandom_range(0, nsym - 1)]);
        close_pat = ($urandom_range(0, 19) != 0);
        for (int i = 0; i < plen; i++)
            send_byte(KIND_PATTERN, pat[i], close_pat && i == plen - 1);

        // texts, most of them holding the pattern somewhere
        ntexts = $urandom_range(1, 3);
        for (int t = 0; t < ntexts; t++) begin
            txt.delete();
            tlen = (plen > 8 ? plen : 0) + $urandom_range(1, 30);
            for (int i = 0; i < tlen; i++)
                txt.push_back(wide ? DATA_W'($urandom_range(0, 255))
                                   : sym[$urandom_range(0, nsym - 1)]);
            if ($urandom_range(0, 9) < 6 && tlen >= plen) begin
                at = $urandom_range(0, tlen - plen);
                for (int i = 0; i < plen; i++)
                    txt[at + i] = pat[i];
            end
            close_txt = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < tlen; i++)
                send_byte(KIND_TEXT, txt[i], close_txt && i == tlen - 1);
        end

        // noise
        if ($urandom_range(0, 99) < 15) begin
            pick = $urandom_range(1, 6);
            repeat (pick)
                send_byte(1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // result side with random stalls
    initial begin : answer_sink
        int stall;
        stall    = 0;
        out_calm = 0;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (out_if.valid && out_if.ready) begin
                sb.check_answer(out_if.status, out_if.position);
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                stall = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // stimulus
    initial begin : byte_source
        sb         = new();
        bytes_sent = 0;
        in_calm    = 0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_PATTERN;
        in_if.data_byte = '0;
        in_if.last      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern right after reset, then text after the match
        send_byte(KIND_TEXT, 8'h41, 1'b0);
        send_byte(KIND_TEXT, 8'h42, 1'b1);
        // two byte pattern at the byte extremes
        send_byte(KIND_PATTERN, 8'h00, 1'b0);
        send_byte(KIND_PATTERN, 8'hFF, 1'b1);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'h00, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'h00, 1'b1);
        // text that ends without a match
        send_byte(KIND_TEXT, 8'h00, 1'b1);
        // new pattern replaces the closed one, needs failure walks
        send_byte(KIND_PATTERN, 8'h61, 1'b0);
        send_byte(KIND_PATTERN, 8'h61, 1'b0);
        send_byte(KIND_PATTERN, 8'h62, 1'b1);
        send_byte(KIND_TEXT, 8'h61, 1'b0);
        send_byte(KIND_TEXT, 8'h61, 1'b0);
        send_byte(KIND_TEXT, 8'h61, 1'b0);
        send_byte(KIND_TEXT, 8'h62, 1'b1);
        // pattern byte in the middle of a search
        send_byte(KIND_TEXT, 8'h61, 1'b0);
        send_byte(KIND_PATTERN, 8'h7F, 1'b1);
        send_byte(KIND_TEXT, 8'h80, 1'b0);
        send_byte(KIND_TEXT, 8'h7F, 1'b1);
        drain_answers();

        // full store, then overflow
        run_round(PATTERN_MAX);
        run_round(PATTERN_MAX + 2);
        drain_answers();

        // random rounds with calm stretches on the sender side
        while (bytes_sent < BYTE_TARGET) begin
            in_calm = ($urandom_range(0, 5) == 0);
            run_round(0);
        end

        drain_answers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("[kmp_string_search_core] OK");
        else
            $display("[kmp_string_search_core] ERROR");
        $finish;
    end

endmodule
